// ===== rtl/optpc_pkg.sv =====
// Shared types, codes and widths for the outline point to path command converter.
// No dependencies.
package optpc_pkg;

	localparam int COORD_BITS  = 24;
	localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((8 * COORD_BITS + 7) / 8) * 8;
	localparam int QDEPTH      = 4;
	localparam int QA          = $clog2(QDEPTH);

	localparam logic [1:0] K_CONIC  = 2'd0;
	localparam logic [1:0] K_ON     = 2'd1;
	localparam logic [1:0] K_CUBIC  = 2'd2;
	localparam logic [1:0] K_ON_ALT = 2'd3;

	localparam logic [1:0] OP_MOVE  = 2'd0;
	localparam logic [1:0] OP_LINE  = 2'd1;
	localparam logic [1:0] OP_CUBIC = 2'd2;
	localparam logic [1:0] OP_CLOSE = 2'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [1:0] op;
		coord_t     from_x;
		coord_t     from_y;
		coord_t     c1_x;
		coord_t     c1_y;
		coord_t     c2_x;
		coord_t     c2_y;
		coord_t     to_x;
		coord_t     to_y;
	} cmd_t;

	// one queue entry: the commands caused by one point
	typedef struct packed {
		logic two;
		cmd_t cmd0;
		cmd_t cmd1;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	typedef struct packed {
		logic empty;
		logic full;
		job_t head;
	} qstat_t;

	function automatic cmd_t mk_cmd(input logic [1:0] op, input coord_t fx, input coord_t fy,
		input coord_t ax, input coord_t ay, input coord_t bx, input coord_t by,
		input coord_t tx, input coord_t ty);
		cmd_t c;
		c.op     = op;
		c.from_x = fx;
		c.from_y = fy;
		c.c1_x   = ax;
		c.c1_y   = ay;
		c.c2_x   = bx;
		c.c2_y   = by;
		c.to_x   = tx;
		c.to_y   = ty;
		return c;
	endfunction

endpackage

// ===== rtl/outline_points_to_path_commands.sv =====
// Top level of the outline point to path command converter.
// Depends on optpc_pkg, optpc_front, optpc_queue and optpc_back.
//
// Outline points go in one a cycle while the job queue is not full: px, py in tdata, kind
// in tuser, last point of a contour on tlast. Each point gives zero, one or two path commands
// (move, line, cubic, close) on the output stream, with tlast on the final command of that
// point; conic segments come out as cubics with both controls equal to the conic control.
// A point giving two commands (a move or segment plus the closing command) has them sent one
// after the other from the output register. The front end and the output register are parted
// by a four-entry job queue, so input is taken while earlier commands still wait at the output.
module outline_points_to_path_commands import optpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // px, py
	input  logic [1:0]             s_tuser,   // kind
	input  logic                   s_tlast,   // contour_end
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // from_x, from_y, c1_x, c1_y, c2_x, c2_y, to_x, to_y
	output logic [1:0]             m_tuser,   // op
	output logic                   m_tlast    // last_of_run
);

	push_t  push;
	qstat_t qstat;
	logic   pop;

	optpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.qstat    (qstat),
		.push     (push)
	);

	optpc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat)
	);

	optpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/optpc_front.sv =====
// Front end: takes outline points, tracks contour state and builds the commands of each point.
// Depends on optpc_pkg.
module optpc_front import optpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // px, py
	input  logic [1:0]            s_tuser,  // kind
	input  logic                  s_tlast,  // contour_end
	input  qstat_t                qstat,
	output push_t                 push
);

	localparam coord_t ZC = '0;

	logic [1:0] prev_kind_q, start_kind_q;
	logic       awaiting_q;
	coord_t     ca_x_q, ca_y_q, cb_x_q, cb_y_q, pen_x_q, pen_y_q;
	coord_t     cs_x_q, cs_y_q, la_x_q, la_y_q, lb_x_q, lb_y_q;

	logic [1:0] prev_kind_n, start_kind_n, kind_n;
	logic       awaiting_n, accept;
	coord_t     ca_x_n, ca_y_n, cb_x_n, cb_y_n, pen_x_n, pen_y_n;
	coord_t     cs_x_n, cs_y_n, la_x_n, la_y_n, lb_x_n, lb_y_n;
	coord_t     p_x, p_y, mid_x, mid_y;
	logic signed [COORD_BITS:0] sum_x, sum_y;
	logic       a_v, b_v;
	cmd_t       cmd_a, cmd_b;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;
	assign p_x      = s_tdata[COORD_BITS-1:0];
	assign p_y      = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign kind_n   = (s_tuser == K_ON_ALT) ? K_ON : s_tuser;

	// implied on-curve point between two conic controls, floor of the mean
	assign sum_x = {p_x[COORD_BITS-1], p_x} + {ca_x_q[COORD_BITS-1], ca_x_q};
	assign sum_y = {p_y[COORD_BITS-1], p_y} + {ca_y_q[COORD_BITS-1], ca_y_q};
	assign mid_x = sum_x[COORD_BITS:1];
	assign mid_y = sum_y[COORD_BITS:1];

	always_comb begin
		prev_kind_n  = kind_n;
		start_kind_n = start_kind_q;
		awaiting_n   = awaiting_q;
		ca_x_n = ca_x_q;  ca_y_n = ca_y_q;
		cb_x_n = cb_x_q;  cb_y_n = cb_y_q;
		pen_x_n = pen_x_q; pen_y_n = pen_y_q;
		cs_x_n = cs_x_q;  cs_y_n = cs_y_q;
		la_x_n = la_x_q;  la_y_n = la_y_q;
		lb_x_n = lb_x_q;  lb_y_n = lb_y_q;
		a_v   = 1'b0;
		b_v   = 1'b0;
		cmd_a = mk_cmd(OP_LINE, ZC, ZC, ZC, ZC, ZC, ZC, p_x, p_y);
		cmd_b = mk_cmd(OP_CLOSE, ZC, ZC, ZC, ZC, ZC, ZC, ZC, ZC);

		if (awaiting_q) begin
			if (kind_n == K_ON) begin
				a_v = 1'b1;
				cmd_a = mk_cmd(OP_MOVE, ZC, ZC, ZC, ZC, ZC, ZC, p_x, p_y);
				pen_x_n = p_x; pen_y_n = p_y;
				cs_x_n  = p_x; cs_y_n  = p_y;
				awaiting_n = 1'b0;
			end else begin
				if (kind_n == K_CUBIC && prev_kind_q == K_CUBIC) begin
					lb_x_n = p_x; lb_y_n = p_y;
				end else begin
					la_x_n = p_x; la_y_n = p_y;
					lb_x_n = p_x; lb_y_n = p_y;
				end
				start_kind_n = kind_n;
			end
		end else if (kind_n == K_CONIC) begin
			if (prev_kind_q == K_CONIC) begin
				a_v = 1'b1;
				cmd_a = mk_cmd(OP_CUBIC, pen_x_q, pen_y_q, ca_x_q, ca_y_q, ca_x_q, ca_y_q,
					mid_x, mid_y);
				pen_x_n = mid_x; pen_y_n = mid_y;
			end
			ca_x_n = p_x; ca_y_n = p_y;
			cb_x_n = p_x; cb_y_n = p_y;
		end else if (kind_n == K_CUBIC) begin
			if (prev_kind_q == K_CUBIC) begin
				cb_x_n = p_x; cb_y_n = p_y;
			end else begin
				ca_x_n = p_x; ca_y_n = p_y;
				cb_x_n = p_x; cb_y_n = p_y;
			end
		end else begin
			a_v = 1'b1;
			case (prev_kind_q)
				K_CONIC: cmd_a = mk_cmd(OP_CUBIC, pen_x_q, pen_y_q, ca_x_q, ca_y_q,
					ca_x_q, ca_y_q, p_x, p_y);
				K_CUBIC: cmd_a = mk_cmd(OP_CUBIC, pen_x_q, pen_y_q, ca_x_q, ca_y_q,
					cb_x_q, cb_y_q, p_x, p_y);
				default: cmd_a = mk_cmd(OP_LINE, ZC, ZC, ZC, ZC, ZC, ZC, p_x, p_y);
			endcase
			pen_x_n = p_x; pen_y_n = p_y;
		end

		if (s_tlast) begin
			if (!awaiting_n) begin
				b_v = 1'b1;
				case (kind_n)
					K_CONIC: cmd_b = mk_cmd(OP_CUBIC, pen_x_n, pen_y_n, ca_x_n, ca_y_n,
						ca_x_n, ca_y_n, cs_x_n, cs_y_n);
					K_CUBIC: cmd_b = mk_cmd(OP_CUBIC, pen_x_n, pen_y_n, ca_x_n, ca_y_n,
						cb_x_n, cb_y_n, cs_x_n, cs_y_n);
					default: begin
						if (start_kind_n == K_ON)
							cmd_b = mk_cmd(OP_CLOSE, ZC, ZC, ZC, ZC, ZC, ZC, ZC, ZC);
						else
							cmd_b = mk_cmd(OP_CUBIC, pen_x_n, pen_y_n, la_x_n, la_y_n,
								lb_x_n, lb_y_n, cs_x_n, cs_y_n);
					end
				endcase
				pen_x_n = cs_x_n; pen_y_n = cs_y_n;
			end
			awaiting_n   = 1'b1;
			prev_kind_n  = K_ON;
			start_kind_n = K_ON;
		end
	end

	always_comb begin
		push.valid    = accept && (a_v || b_v);
		push.job.two  = a_v && b_v;
		push.job.cmd0 = a_v ? cmd_a : cmd_b;
		push.job.cmd1 = cmd_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_kind_q  <= K_ON;
			start_kind_q <= K_ON;
			awaiting_q   <= 1'b1;
			ca_x_q <= '0;  ca_y_q <= '0;
			cb_x_q <= '0;  cb_y_q <= '0;
			pen_x_q <= '0; pen_y_q <= '0;
			cs_x_q <= '0;  cs_y_q <= '0;
			la_x_q <= '0;  la_y_q <= '0;
			lb_x_q <= '0;  lb_y_q <= '0;
		end else if (accept) begin
			prev_kind_q  <= prev_kind_n;
			start_kind_q <= start_kind_n;
			awaiting_q   <= awaiting_n;
			ca_x_q <= ca_x_n;   ca_y_q <= ca_y_n;
			cb_x_q <= cb_x_n;   cb_y_q <= cb_y_n;
			pen_x_q <= pen_x_n; pen_y_q <= pen_y_n;
			cs_x_q <= cs_x_n;   cs_y_q <= cs_y_n;
			la_x_q <= la_x_n;   la_y_q <= la_y_n;
			lb_x_q <= lb_x_n;   lb_y_q <= lb_y_n;
		end
	end

endmodule

// ===== rtl/optpc_queue.sv =====
// Short job queue between the front end and the command output stage.
// Depends on optpc_pkg.
module optpc_queue import optpc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  push_t  push,
	input  logic   pop,
	output qstat_t qstat
);

	job_t          mem_q [QDEPTH];
	logic [QA-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA:0]   count_q;
	logic          do_push, do_pop;

	assign qstat.full  = (count_q == (QA+1)'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign qstat.head  = mem_q[rd_ptr_q];
	assign do_push     = push.valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/optpc_back.sv =====
// Back end: unpacks queued jobs into single commands and holds the output register.
// Depends on optpc_pkg.
module optpc_back import optpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  qstat_t                 qstat,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // from_x, from_y, c1_x, c1_y, c2_x, c2_y, to_x, to_y
	output logic [1:0]             m_tuser,  // op
	output logic                   m_tlast   // last_of_run
);

	logic out_valid_q, pend_q, out_last_q, out_free;
	cmd_t out_cmd_q, pend_cmd_q;

	assign out_free = !out_valid_q || m_tready;
	assign pop      = out_free && !pend_q && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!qstat.empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= qstat.head.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				out_cmd_q  <= pend_cmd_q;
				out_last_q <= 1'b1;
			end else if (!qstat.empty) begin
				out_cmd_q  <= qstat.head.cmd0;
				out_last_q <= !qstat.head.two;
				pend_cmd_q <= qstat.head.cmd1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_cmd_q.op;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_TDATA_W'({out_cmd_q.to_y, out_cmd_q.to_x, out_cmd_q.c2_y,
		out_cmd_q.c2_x, out_cmd_q.c1_y, out_cmd_q.c1_x, out_cmd_q.from_y, out_cmd_q.from_x});

endmodule

// ===== rtl/optpc_checker.sv =====
// Port-level checks on the outline point to path command converter, bound to the top level.
// Depends on optpc_pkg and outline_points_to_path_commands.
module optpc_checker import optpc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [1:0]             m_tuser,
	input logic                   m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output request changed while stalled");

	a_close_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OP_CLOSE |-> m_tdata == '0)
		else $error("close_path carries coordinates");

	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == OP_CLOSE |-> m_tlast)
		else $error("close_path not last of its run");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == OP_MOVE || m_tuser == OP_LINE)
			|-> m_tdata[6*COORD_BITS-1:0] == '0)
		else $error("move or line carries pen or controls");

endmodule

bind outline_points_to_path_commands optpc_checker u_optpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== bench/tb.sv =====
// Self-checking bench for outline_points_to_path_commands: streams outline points in and
// compares every path command against an in-bench predictor. Depends on optpc_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import optpc_pkg::*;

	localparam int     LIMIT_CYCLES = 400000;
	localparam int     PHASE_POINTS = 317;
	localparam coord_t C_MAX        = 24'sh7FFFFF;
	localparam coord_t C_MIN        = 24'sh800000;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} pt_t;

	typedef struct packed {
		cmd_t cmd;
		logic last;
	} path_cmd_t;

	// directed point; where typed is set the single command is written out here
	typedef struct packed {
		coord_t     x;
		coord_t     y;
		logic [1:0] kind;
		logic       cend;
		logic       typed;
		logic [1:0] op;
		coord_t     tx;
		coord_t     ty;
	} dir_row_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [1:0]             s_tuser  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	outline_points_to_path_commands dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [1:0] prev_kind_q  = K_ON;
	logic [1:0] start_kind_q = K_ON;
	logic       seek_on_q    = 1'b1;
	pt_t        ctl_a = '0, ctl_b = '0, pen = '0, origin = '0, lead_a = '0, lead_b = '0;

	path_cmd_t  owed_cmds[$];
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         mismatches    = 0;
	int         cmds_seen     = 0;
	int         points_sent   = 0;
	int         phase_points  = 0;
	int         cycle_count   = 0;

	dir_row_t directed_points [24] = '{
		'{C_MAX, C_MIN, K_ON,     1'b0, 1'b1, OP_MOVE, C_MAX, C_MIN},
		'{24'sd0, 24'sd0, K_ON_ALT, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{C_MIN, C_MAX, K_CONIC,  1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{C_MAX, C_MIN, K_CONIC,  1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{-24'sd1, -24'sd1, K_CUBIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd1, 24'sd1, K_CUBIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{C_MIN, C_MIN, K_ON,     1'b1, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd100, 24'sd200, K_CONIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{C_MIN, C_MAX, K_ON,     1'b0, 1'b1, OP_MOVE, C_MIN, C_MAX},
		'{24'sd5, 24'sd5, K_CUBIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd6, 24'sd6, K_ON,   1'b1, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd7, -24'sd7, K_CUBIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{-24'sd9, 24'sd9, K_CUBIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd3, 24'sd4, K_ON,   1'b0, 1'b1, OP_MOVE, 24'sd3, 24'sd4},
		'{24'sd11, 24'sd13, K_CONIC, 1'b1, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd1, 24'sd2, K_CONIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd3, 24'sd4, K_CUBIC, 1'b1, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{-24'sd5, -24'sd6, K_ON, 1'b1, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{C_MAX, C_MAX, K_CUBIC,  1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{24'sd0, 24'sd0, K_ON,   1'b0, 1'b1, OP_MOVE, 24'sd0, 24'sd0},
		'{C_MIN, C_MAX, K_CUBIC,  1'b1, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{-24'sd3, -24'sd3, K_CONIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{-24'sd4, -24'sd4, K_CONIC, 1'b0, 1'b0, OP_MOVE, 24'sd0, 24'sd0},
		'{C_MAX, C_MAX, K_ON_ALT, 1'b1, 1'b0, OP_MOVE, 24'sd0, 24'sd0}
	};

	function automatic cmd_t make_cmd(input logic [1:0] op, input pt_t f, input pt_t a,
		input pt_t b, input pt_t t);
		cmd_t c;
		c.op     = op;
		c.from_x = f.x;
		c.from_y = f.y;
		c.c1_x   = a.x;
		c.c1_y   = a.y;
		c.c2_x   = b.x;
		c.c2_y   = b.y;
		c.to_x   = t.x;
		c.to_y   = t.y;
		return c;
	endfunction

	// implied on-curve point between two conic controls, floor of the sum halved
	function automatic pt_t conic_midpoint(input pt_t p, input pt_t q);
		logic signed [COORD_BITS:0] sx, sy;
		pt_t m;
		sx  = $signed(p.x) + $signed(q.x);
		sy  = $signed(p.y) + $signed(q.y);
		m.x = sx[COORD_BITS:1];
		m.y = sy[COORD_BITS:1];
		return m;
	endfunction

	function automatic int step_outline(input pt_t p, input logic [1:0] kind_in,
		input logic cend, output cmd_t c[2]);
		logic [1:0] k;
		int         n;
		pt_t        zero, m;
		k    = (kind_in == K_ON_ALT) ? K_ON : kind_in;
		n    = 0;
		zero = '0;
		c[0] = '0;
		c[1] = '0;
		if (seek_on_q) begin
			if (k == K_ON) begin
				c[n] = make_cmd(OP_MOVE, zero, zero, zero, p);
				n = n + 1;
				pen = p;
				origin = p;
				if (prev_kind_q == K_ON)
					start_kind_q = K_ON;
				seek_on_q = 1'b0;
			end else begin
				if (k == K_CUBIC && prev_kind_q == K_CUBIC) begin
					lead_b = p;
				end else begin
					lead_a = p;
					lead_b = p;
				end
				start_kind_q = k;
			end
		end else if (k == K_CONIC) begin
			if (prev_kind_q == K_CONIC) begin
				m = conic_midpoint(p, ctl_a);
				c[n] = make_cmd(OP_CUBIC, pen, ctl_a, ctl_a, m);
				n = n + 1;
				pen = m;
			end
			ctl_a = p;
			ctl_b = p;
		end else if (k == K_CUBIC) begin
			if (prev_kind_q == K_CUBIC) begin
				ctl_b = p;
			end else begin
				ctl_a = p;
				ctl_b = p;
			end
		end else begin
			if (prev_kind_q == K_CONIC)
				c[n] = make_cmd(OP_CUBIC, pen, ctl_a, ctl_a, p);
			else if (prev_kind_q == K_CUBIC)
				c[n] = make_cmd(OP_CUBIC, pen, ctl_a, ctl_b, p);
			else
				c[n] = make_cmd(OP_LINE, zero, zero, zero, p);
			n = n + 1;
			pen = p;
		end
		prev_kind_q = k;

		if (cend) begin
			if (!seek_on_q) begin
				if (k == K_ON) begin
					if (start_kind_q == K_ON)
						c[n] = make_cmd(OP_CLOSE, zero, zero, zero, zero);
					else
						c[n] = make_cmd(OP_CUBIC, pen, lead_a, lead_b, origin);
				end else if (k == K_CONIC) begin
					c[n] = make_cmd(OP_CUBIC, pen, ctl_a, ctl_a, origin);
				end else begin
					c[n] = make_cmd(OP_CUBIC, pen, ctl_a, ctl_b, origin);
				end
				n = n + 1;
				pen = origin;
			end
			seek_on_q    = 1'b1;
			prev_kind_q  = K_ON;
			start_kind_q = K_ON;
		end
		return n;
	endfunction

	task automatic report_mismatch(input string what, input logic [COORD_BITS-1:0] want,
		input logic [COORD_BITS-1:0] seen);
		mismatches++;
		$display("mismatch at command %0d, %s: expected %0h, got %0h",
			cmds_seen, what, want, seen);
	endtask

	function automatic coord_t rand_coord();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return coord_t'($urandom);
		else if (r < 70)
			case ($urandom_range(4))
				0: return C_MAX;
				1: return C_MIN;
				2: return 24'sd0;
				3: return -24'sd1;
				default: return 24'sd1;
			endcase
		return coord_t'($urandom_range(2000)) - 24'sd1000;
	endfunction

	// entered and left at a rising edge
	task automatic send_point(input coord_t x, input coord_t y, input logic [1:0] k,
		input logic e, input logic typed, input cmd_t typed_cmd);
		cmd_t      c[2];
		int        n;
		path_cmd_t pc;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tuser  <= k;
		s_tlast  <= e;
		// hold the request until taken at the coming edge
		do @(negedge clk); while (!s_tready);
		n = step_outline('{x: x, y: y}, k, e, c);
		if (typed) begin
			pc.cmd  = typed_cmd;
			pc.last = 1'b1;
			owed_cmds.push_back(pc);
		end else begin
			for (int i = 0; i < n; i++) begin
				pc.cmd  = c[i];
				pc.last = (i == n - 1);
				owed_cmds.push_back(pc);
			end
		end
		points_sent++;
		phase_points++;
		@(posedge clk);
	endtask

	task automatic drain_commands();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_cmds.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_contour();
		int         mode, nlead, nbody, r;
		logic [1:0] k;
		if ($urandom_range(99) < 2)
			drain_commands();
		mode = $urandom_range(99);
		if (mode < 80) begin
			nlead = ($urandom_range(99) < 60) ? 0 : $urandom_range(2, 1);
			nbody = $urandom_range(7, 1);
			for (int i = 0; i < nlead; i++)
				send_point(rand_coord(), rand_coord(),
					$urandom_range(1) ? K_CUBIC : K_CONIC, 1'b0, 1'b0, '0);
			for (int i = 0; i < nbody; i++) begin
				if (i == 0) begin
					k = ($urandom_range(9) == 0) ? K_ON_ALT : K_ON;
				end else begin
					r = $urandom_range(99);
					k = (r < 40) ? K_ON : (r < 70) ? K_CONIC : (r < 95) ? K_CUBIC : K_ON_ALT;
				end
				send_point(rand_coord(), rand_coord(), k, i == nbody - 1, 1'b0, '0);
			end
		end else if (mode < 90) begin
			// contour without any on-curve point
			nbody = $urandom_range(3, 1);
			for (int i = 0; i < nbody; i++)
				send_point(rand_coord(), rand_coord(),
					$urandom_range(1) ? K_CUBIC : K_CONIC, i == nbody - 1, 1'b0, '0);
		end else begin
			nbody = $urandom_range(4, 1);
			for (int i = 0; i < nbody; i++)
				send_point(rand_coord(), rand_coord(), 2'($urandom_range(3)),
					$urandom_range(3) == 0, 1'b0, '0);
		end
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// sampled mid-cycle: what is seen here is taken at the next rising edge
	always @(negedge clk) begin
		path_cmd_t              want;
		logic [OUT_TDATA_W-1:0] want_data;
		string                  names [8];
		names = '{"from_x", "from_y", "c1_x", "c1_y", "c2_x", "c2_y", "to_x", "to_y"};
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_cmds.size() == 0) begin
				report_mismatch("unexpected command, op", '0, COORD_BITS'(m_tuser));
			end else begin
				want = owed_cmds.pop_front();
				want_data = {want.cmd.to_y, want.cmd.to_x, want.cmd.c2_y, want.cmd.c2_x,
					want.cmd.c1_y, want.cmd.c1_x, want.cmd.from_y, want.cmd.from_x};
				if (m_tuser !== want.cmd.op)
					report_mismatch("op", COORD_BITS'(want.cmd.op), COORD_BITS'(m_tuser));
				if (m_tlast !== want.last)
					report_mismatch("last_of_run", COORD_BITS'(want.last),
						COORD_BITS'(m_tlast));
				for (int i = 0; i < 8; i++)
					if (m_tdata[i*COORD_BITS +: COORD_BITS] !== want_data[i*COORD_BITS +: COORD_BITS])
						report_mismatch(names[i], want_data[i*COORD_BITS +: COORD_BITS],
							m_tdata[i*COORD_BITS +: COORD_BITS]);
			end
			cmds_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		cmd_t tc;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 86;
		foreach (directed_points[i]) begin
			tc = '0;
			tc.op   = directed_points[i].op;
			tc.to_x = directed_points[i].tx;
			tc.to_y = directed_points[i].ty;
			send_point(directed_points[i].x, directed_points[i].y, directed_points[i].kind,
				directed_points[i].cend, directed_points[i].typed, tc);
		end

		for (int ph = 0; ph < 3; ph++) begin
			drain_commands();
			send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 86 : 0;
			recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 10 : 0;
			phase_points  = 0;
			while (phase_points < PHASE_POINTS)
				send_contour();
		end

		drain_commands();
		repeat (16) @(posedge clk);
		if (owed_cmds.size() != 0)
			report_mismatch("commands never delivered", '0, COORD_BITS'(owed_cmds.size()));

		$display("sent %0d outline points, checked %0d path commands", points_sent, cmds_seen);
		$display("covered directed corner cases and three sender/receiver stall profiles");
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
